// ----- hdl/gre_pkg.sv -----
// shared types and constants for the genome rearrangement engine
package gre_pkg;

  localparam int DEF_MAX_GENES   = 64;
  localparam int DEF_LABEL_BITS  = 16;
  localparam int DEF_REGION_BITS = 16;
  localparam int POS_BITS        = 7;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_REVERSE = 3'd3,
    CMD_TRANSPOSE = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

endpackage

// ----- hdl/gre_store.sv -----
// gene and region arrays, two registered read ports and one write port each
module gre_store import gre_pkg::*; #(
  parameter int DEPTH = DEF_MAX_GENES,
  parameter int GB    = DEF_LABEL_BITS,
  parameter int RB    = DEF_REGION_BITS
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] ra_g,
  input  logic [$clog2(DEPTH)-1:0] rb_g,
  input  logic [$clog2(DEPTH)-1:0] ra_r,
  input  logic [$clog2(DEPTH)-1:0] rb_r,
  output logic [GB-1:0]            qa_g,
  output logic [GB-1:0]            qb_g,
  output logic [RB-1:0]            qa_r,
  output logic [RB-1:0]            qb_r,
  input  logic                     we_g,
  input  logic [$clog2(DEPTH)-1:0] wa_g,
  input  logic [GB-1:0]            wd_g,
  input  logic                     we_r,
  input  logic [$clog2(DEPTH)-1:0] wa_r,
  input  logic [RB-1:0]            wd_r
);

  logic [GB-1:0] gmem [DEPTH];
  logic [RB-1:0] rmem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_g) begin
      gmem[wa_g] <= wd_g;
    end
    qa_g <= gmem[ra_g];
    qb_g <= gmem[rb_g];
  end

  always_ff @(posedge clk) begin
    if (we_r) begin
      rmem[wa_r] <= wd_r;
    end
    qa_r <= rmem[ra_r];
    qb_r <= rmem[rb_r];
  end

endmodule

// ----- hdl/gre_seq.sv -----
// command sequencer with the shared saturating adder and element mover
module gre_seq import gre_pkg::*; #(
  parameter int MAX_GENES   = DEF_MAX_GENES,
  parameter int LABEL_BITS  = DEF_LABEL_BITS,
  parameter int REGION_BITS = DEF_REGION_BITS,
  localparam int AW = $clog2(MAX_GENES),
  localparam int CW = $clog2(MAX_GENES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output logic                          done,
  input  cmd_t                          cmd_in,
  input  logic [POS_BITS-1:0]           pf,
  input  logic [POS_BITS-1:0]           ps,
  input  logic [POS_BITS-1:0]           pt,
  input  logic [REGION_BITS-1:0]        ax,
  input  logic [REGION_BITS-1:0]        ay,
  input  logic [REGION_BITS-1:0]        az,
  input  logic [LABEL_BITS-1:0]         gene_in,
  input  logic [REGION_BITS-1:0]        region_in,
  output logic [CW-1:0]                 count,
  output status_t                       res_status,
  output logic signed [LABEL_BITS-1:0]  res_gene,
  output logic [REGION_BITS-1:0]        res_region,
  // main store
  output logic [AW-1:0]                 m_ra_g,
  output logic [AW-1:0]                 m_rb_g,
  output logic [AW-1:0]                 m_ra_r,
  output logic [AW-1:0]                 m_rb_r,
  input  logic [LABEL_BITS-1:0]         m_qa_g,
  input  logic [LABEL_BITS-1:0]         m_qb_g,
  input  logic [REGION_BITS-1:0]        m_qa_r,
  input  logic [REGION_BITS-1:0]        m_qb_r,
  output logic                          m_we_g,
  output logic [AW-1:0]                 m_wa_g,
  output logic [LABEL_BITS-1:0]         m_wd_g,
  output logic                          m_we_r,
  output logic [AW-1:0]                 m_wa_r,
  output logic [REGION_BITS-1:0]        m_wd_r,
  // scratch store for the moved block
  output logic [AW-1:0]                 s_ra,
  input  logic [LABEL_BITS-1:0]         s_q_g,
  input  logic [REGION_BITS-1:0]        s_q_r,
  output logic                          s_we,
  output logic [AW-1:0]                 s_wa
);

  localparam int IW = ((CW > POS_BITS) ? CW : POS_BITS) + 1;
  localparam int RB = REGION_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_CHK, S_CHK2, S_EVAL,
    S_MOVE_RD, S_MOVE_WR, S_SWAP_RD, S_SWAP_WA, S_SWAP_WB,
    S_BLK_RD, S_BLK_WR, S_BACK_RD, S_BACK_WR,
    S_FIX1, S_FIX2, S_FIX3
  } state_t;

  state_t state;
  cmd_t   cmd;
  logic [AW-1:0] im1, im2, jm1, jm2, km2, endc;
  logic [AW-1:0] s, d, c, a, b;
  logic [RB-1:0] x, y, z, xr, yr, zr;
  logic          bad, rd_last;

  logic [IW-1:0] pfw, psw, ptw, nn;
  logic          del_ok, rev_ok, tr_ok, rd_ok;
  logic [AW-1:0] nm1;
  logic [RB:0]   del_sum;
  logic [RB-1:0] sat_a, sat_b, sat_q;
  logic [RB:0]   sat_s;

  assign pfw = IW'(pf);
  assign psw = IW'(ps);
  assign ptw = IW'(pt);
  assign nn  = IW'(count);
  assign del_ok = (pfw >= IW'(2)) && (pfw < psw) && (psw <= nn);
  assign rev_ok = (pfw >= IW'(2)) && (pfw <= psw) && (psw < nn);
  assign tr_ok  = (pfw >= IW'(2)) && (pfw < psw) && (psw < ptw) && (ptw <= nn);
  assign rd_ok  = (pfw >= IW'(1)) && (pfw <= nn);
  assign nm1    = AW'(nn - IW'(1));
  assign del_sum = {1'b0, m_qa_r} + {1'b0, m_qb_r};
  assign busy   = (state != S_IDLE);

  // shared saturating adder for the boundary regions
  always_comb begin
    sat_a = x;
    sat_b = y;
    if (cmd == CMD_REVERSE) begin
      if (state == S_FIX2) begin
        sat_a = xr;
        sat_b = yr;
      end
    end else begin
      unique case (state)
        S_FIX1:  begin sat_a = x; sat_b = yr; end
        S_FIX2:  begin sat_a = z; sat_b = xr; end
        default: begin sat_a = y; sat_b = zr; end
      endcase
    end
  end
  assign sat_s = {1'b0, sat_a} + {1'b0, sat_b};
  assign sat_q = sat_s[RB] ? {RB{1'b1}} : sat_s[RB-1:0];

  // memory control
  always_comb begin
    m_ra_g = '0; m_rb_g = '0; m_ra_r = '0; m_rb_r = '0;
    m_we_g = 1'b0; m_wa_g = '0; m_wd_g = m_qa_g;
    m_we_r = 1'b0; m_wa_r = '0; m_wd_r = m_qa_r;
    s_ra = c; s_we = 1'b0; s_wa = c;
    unique case (state)
      S_IDLE: begin
        m_ra_g = AW'(pfw - IW'(1));
        m_ra_r = AW'(pfw - IW'(1));
        if (start && cmd_in == CMD_APPEND && count < CW'(MAX_GENES)) begin
          m_we_g = 1'b1;
          m_wa_g = AW'(count);
          m_wd_g = gene_in;
          m_we_r = (count != '0);
          m_wa_r = AW'(nn - IW'(1));
          m_wd_r = region_in;
        end
      end
      S_CHK: begin
        m_ra_r = im2;
        m_rb_r = (cmd == CMD_REVERSE) ? jm1 : jm2;
      end
      S_CHK2: m_ra_r = km2;
      S_EVAL: begin
        if (cmd == CMD_DELETE && {1'b0, x} <= del_sum) begin
          m_we_r = 1'b1;
          m_wa_r = im2;
          m_wd_r = x;
        end
      end
      S_MOVE_RD, S_BLK_RD: begin
        m_ra_g = s;
        m_ra_r = s;
      end
      S_MOVE_WR: begin
        m_we_g = 1'b1;
        m_wa_g = d;
        m_we_r = (cmd == CMD_TRANSPOSE) || (s != nm1);
        m_wa_r = d;
      end
      S_SWAP_RD, S_SWAP_WA: begin
        m_ra_g = a;
        m_rb_g = b;
        m_ra_r = a;
        m_rb_r = b - AW'(1);
        if (state == S_SWAP_WA) begin
          m_we_g = 1'b1; m_wa_g = a; m_wd_g = m_qb_g;
          m_we_r = 1'b1; m_wa_r = a; m_wd_r = m_qb_r;
        end
      end
      S_SWAP_WB: begin
        m_we_g = 1'b1; m_wa_g = b;
        m_we_r = 1'b1; m_wa_r = b - AW'(1);
      end
      S_BLK_WR: s_we = 1'b1;
      S_BACK_WR: begin
        m_we_g = 1'b1; m_wa_g = d; m_wd_g = s_q_g;
        m_we_r = 1'b1; m_wa_r = d; m_wd_r = s_q_r;
      end
      S_FIX1: begin
        m_we_r = 1'b1; m_wa_r = im2; m_wd_r = sat_q;
      end
      S_FIX2: begin
        m_we_r = 1'b1;
        m_wa_r = (cmd == CMD_REVERSE) ? jm1 : (im2 + km2 - jm2);
        m_wd_r = sat_q;
      end
      S_FIX3: begin
        m_we_r = 1'b1; m_wa_r = km2; m_wd_r = sat_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= cmd_in;
            im1 <= AW'(pfw - IW'(1));
            im2 <= AW'(pfw - IW'(2));
            jm1 <= AW'(psw - IW'(1));
            jm2 <= AW'(psw - IW'(2));
            km2 <= AW'(ptw - IW'(2));
            endc <= AW'(psw - pfw - IW'(1));
            x <= ax;
            y <= ay;
            z <= az;
            rd_last <= (pfw == nn);
            res_status <= ST_OK;
            res_gene   <= '0;
            res_region <= '0;
            unique case (cmd_in)
              CMD_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              CMD_APPEND: begin
                done <= 1'b1;
                if (count < CW'(MAX_GENES)) begin
                  count <= count + CW'(1);
                end else begin
                  res_status <= ST_FULL;
                end
              end
              CMD_DELETE, CMD_REVERSE, CMD_TRANSPOSE: begin
                if ((cmd_in == CMD_DELETE && del_ok) ||
                    (cmd_in == CMD_REVERSE && rev_ok) ||
                    (cmd_in == CMD_TRANSPOSE && tr_ok)) begin
                  state <= S_CHK;
                end else begin
                  res_status <= ST_BAD;
                  done <= 1'b1;
                end
              end
              CMD_READ: begin
                if (rd_ok) begin
                  state <= S_READ;
                end else begin
                  res_status <= ST_BAD;
                  done <= 1'b1;
                end
              end
              default: begin
                res_status <= ST_BAD;
                done <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          res_gene   <= $signed(m_qa_g);
          res_region <= rd_last ? '0 : m_qa_r;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_CHK: state <= (cmd == CMD_TRANSPOSE) ? S_CHK2 : S_EVAL;
        S_CHK2: begin
          xr  <= m_qa_r - x;
          yr  <= m_qb_r - y;
          bad <= (x > m_qa_r) || (y > m_qb_r);
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (cmd == CMD_DELETE) begin
            if ({1'b0, x} > del_sum) begin
              res_status <= ST_BAD;
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              s <= jm1;
              d <= im1;
              state <= S_MOVE_RD;
            end
          end else if (cmd == CMD_REVERSE) begin
            if ((x > m_qa_r) || (y > m_qb_r)) begin
              res_status <= ST_BAD;
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              xr <= m_qa_r - x;
              yr <= m_qb_r - y;
              a  <= im1;
              b  <= jm1;
              state <= (im1 < jm1) ? S_SWAP_RD : S_FIX1;
            end
          end else begin
            if (bad || (z > m_qa_r)) begin
              res_status <= ST_BAD;
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              zr <= m_qa_r - z;
              s  <= im1;
              c  <= '0;
              state <= S_BLK_RD;
            end
          end
        end
        S_BLK_RD: state <= S_BLK_WR;
        S_BLK_WR: begin
          if (s == jm2) begin
            s <= jm1;
            d <= im1;
            state <= S_MOVE_RD;
          end else begin
            s <= s + AW'(1);
            c <= c + AW'(1);
            state <= S_BLK_RD;
          end
        end
        S_MOVE_RD: state <= S_MOVE_WR;
        S_MOVE_WR: begin
          s <= s + AW'(1);
          d <= d + AW'(1);
          if (cmd == CMD_DELETE && s == nm1) begin
            count <= CW'(d) + CW'(1);
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (cmd == CMD_TRANSPOSE && s == km2) begin
            c <= '0;
            state <= S_BACK_RD;
          end else begin
            state <= S_MOVE_RD;
          end
        end
        S_BACK_RD: state <= S_BACK_WR;
        S_BACK_WR: begin
          d <= d + AW'(1);
          c <= c + AW'(1);
          state <= (c == endc) ? S_FIX1 : S_BACK_RD;
        end
        S_SWAP_RD: state <= S_SWAP_WA;
        S_SWAP_WA: state <= S_SWAP_WB;
        S_SWAP_WB: begin
          a <= a + AW'(1);
          b <= b - AW'(1);
          state <= ((a + AW'(1)) < (b - AW'(1))) ? S_SWAP_RD : S_FIX1;
        end
        S_FIX1: state <= S_FIX2;
        S_FIX2: begin
          if (cmd == CMD_REVERSE) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_FIX3;
          end
        end
        S_FIX3: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/genome_rearrangement_engine_top.sv -----
// top level of the genome rearrangement engine
//
// A command transaction is taken on a rising edge with start high and busy
// low; command, positions, amounts, gene_value and region_value are sampled
// there. Exactly one result follows: status, gene_out, region_out and
// length_out are valid for the single cycle in which done is high, and the
// receiver must take it then, as it cannot hold results off. busy is low
// again in that same cycle, so the next command may be issued with it.
// Clear, append and commands refused on their positions are answered from
// the idle state, a read after its read state; a command refused on its
// amounts ends after its check and evaluate states. Deletion, reversal and
// transposition move elements through the store, each element by a read of
// the store and a later write. Synchronous reset empties the genome (length
// zero); store contents are left as they are and are never read before
// being rewritten.
module genome_rearrangement_engine_top import gre_pkg::*; #(
  parameter int MAX_GENES   = DEF_MAX_GENES,
  parameter int LABEL_BITS  = DEF_LABEL_BITS,
  parameter int REGION_BITS = DEF_REGION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command,
  input  logic [6:0]         pos_first,
  input  logic [6:0]         pos_second,
  input  logic [6:0]         pos_third,
  input  logic [15:0]        amount_x,
  input  logic [15:0]        amount_y,
  input  logic [15:0]        amount_z,
  input  logic signed [15:0] gene_value,
  input  logic [15:0]        region_value,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [15:0] gene_out,
  output logic [15:0]        region_out,
  output logic [6:0]         length_out
);

  localparam int AW = $clog2(MAX_GENES);
  localparam int CW = $clog2(MAX_GENES + 1);

  logic [CW-1:0]                count;
  status_t                      res_status;
  logic signed [LABEL_BITS-1:0] res_gene;
  logic [REGION_BITS-1:0]       res_region;

  logic [AW-1:0]          m_ra_g, m_rb_g, m_ra_r, m_rb_r, m_wa_g, m_wa_r;
  logic [LABEL_BITS-1:0]  m_qa_g, m_qb_g, m_wd_g;
  logic [REGION_BITS-1:0] m_qa_r, m_qb_r, m_wd_r;
  logic                   m_we_g, m_we_r;
  logic [AW-1:0]          s_ra, s_wa;
  logic [LABEL_BITS-1:0]  s_q_g, s_qb_g;
  logic [REGION_BITS-1:0] s_q_r, s_qb_r;
  logic                   s_we;

  gre_seq #(
    .MAX_GENES(MAX_GENES), .LABEL_BITS(LABEL_BITS), .REGION_BITS(REGION_BITS)
  ) u_seq (
    .clk, .rst, .start, .busy, .done,
    .cmd_in     (cmd_t'(command)),
    .pf         (pos_first),
    .ps         (pos_second),
    .pt         (pos_third),
    .ax         (REGION_BITS'(amount_x)),
    .ay         (REGION_BITS'(amount_y)),
    .az         (REGION_BITS'(amount_z)),
    .gene_in    (LABEL_BITS'(gene_value)),
    .region_in  (REGION_BITS'(region_value)),
    .count, .res_status, .res_gene, .res_region,
    .m_ra_g, .m_rb_g, .m_ra_r, .m_rb_r,
    .m_qa_g, .m_qb_g, .m_qa_r, .m_qb_r,
    .m_we_g, .m_wa_g, .m_wd_g, .m_we_r, .m_wa_r, .m_wd_r,
    .s_ra, .s_q_g, .s_q_r, .s_we, .s_wa
  );

  gre_store #(.DEPTH(MAX_GENES), .GB(LABEL_BITS), .RB(REGION_BITS)) u_main (
    .clk,
    .ra_g(m_ra_g), .rb_g(m_rb_g), .ra_r(m_ra_r), .rb_r(m_rb_r),
    .qa_g(m_qa_g), .qb_g(m_qb_g), .qa_r(m_qa_r), .qb_r(m_qb_r),
    .we_g(m_we_g), .wa_g(m_wa_g), .wd_g(m_wd_g),
    .we_r(m_we_r), .wa_r(m_wa_r), .wd_r(m_wd_r)
  );

  // holds the leading block of a transposition while the trailing one moves
  gre_store #(.DEPTH(MAX_GENES), .GB(LABEL_BITS), .RB(REGION_BITS)) u_scratch (
    .clk,
    .ra_g(s_ra), .rb_g(s_ra), .ra_r(s_ra), .rb_r(s_ra),
    .qa_g(s_q_g), .qb_g(s_qb_g), .qa_r(s_q_r), .qb_r(s_qb_r),
    .we_g(s_we), .wa_g(s_wa), .wd_g(m_qa_g),
    .we_r(s_we), .wa_r(s_wa), .wd_r(m_qa_r)
  );

  assign status     = res_status;
  assign gene_out   = 16'(res_gene);
  assign region_out = 16'(res_region);
  assign length_out = 7'(count);

endmodule
